/* design/wse_pkg.sv */
// ----------------------------------------------------------------------------
// wse_pkg
// Shared constants and types for the WAV stream sample extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package wse_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] CFG_CHANNELS_RST = 16'd1;
    localparam logic [31:0] CFG_RATE_RST     = 32'd24000;
    localparam logic [31:0] CFG_MAXCHK_RST   = 32'd1073741824;

    localparam logic [15:0] FMT_PCM   = 16'd1;
    localparam logic [15:0] FMT_FLOAT = 16'd3;

    localparam logic [31:0] FLT_ONE_MAG = 32'h3F80_0000;
    localparam logic [31:0] FLT_EXP_ALL = 32'h7F80_0000;

    typedef enum logic [1:0] {
        CFG_CHANNELS = 2'd0,
        CFG_RATE     = 2'd1,
        CFG_MAXCHK   = 2'd2
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_BAD_TAGS  = 4'd1,
        ST_TRUNC     = 4'd2,
        ST_TOO_LARGE = 4'd3,
        ST_FMT_SMALL = 4'd4,
        ST_MISSING   = 4'd5,
        ST_CHAN_RATE = 4'd6,
        ST_PARTIAL   = 4'd7,
        ST_NONFINITE = 4'd8,
        ST_FORMAT    = 4'd9,
        ST_DATA_1ST  = 4'd10
    } t_status;

    typedef enum logic [2:0] {
        PH_RIFF = 3'd0,
        PH_HDR  = 3'd1,
        PH_FMT  = 3'd2,
        PH_SKIP = 3'd3,
        PH_DATA = 3'd4,
        PH_DONE = 3'd5
    } t_phase;

    typedef struct packed {
        logic        sv;
        logic [31:0] bits;
        logic        last;
        logic        stv;
        t_status     st;
    } t_result;

endpackage

`default_nettype wire

/* design/wav_stream_sample_extractor_top.sv */
// ----------------------------------------------------------------------------
// wav_stream_sample_extractor_top
// Byte-serial RIFF/WAVE parser that streams float32 audio samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the file one byte per item; tlast marks the final byte.
//   m_axis carries zero or one result item per input byte: a sample, a
//   status, or both. tuser flags which parts are valid, tlast marks the
//   last sample of the data chunk.
//   The cfg channel (always ready) writes required_channels (0), required_rate (1) and
//   max_chunk_size (2); the user must ensure it is written while idle, not the block.
// Latency / throughput:
//   One byte per cycle sustained while the output is not stalled. A byte is
//   decoded by combinational logic in the cycle it is accepted and its result
//   lands in the output register, so it appears in the cycle after its byte.
// Stall:
//   s_axis_tready is high while the output register is empty or being
//   drained this cycle; a stalled receiver holds the result and blocks input.
// Reset:
//   Synchronous, active low. Parser returns to the RIFF header phase and the
//   registers to their defaults. After a status is reported every later
//   byte is swallowed without result until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_stream_sample_extractor_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] file_byte
    input  wire logic        s_axis_tlast,   // end_of_file
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] sample_bits, [35:32] status, rest 0
    output logic [1:0]       m_axis_tuser,   // [0] sample_valid, [1] status_valid
    output logic             m_axis_tlast,   // last_sample
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    // configuration
    logic [15:0] r_req_chan;
    logic [31:0] r_req_rate;
    logic [31:0] r_max_chk;

    // parser state
    wse_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_cnt, n_cnt;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_len, n_len;
    logic [15:0] r_fmt, n_fmt;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_width, n_width;
    logic        r_fmt_seen, n_fmt_seen;
    logic        r_pad, n_pad;
    logic [23:0] r_gather, n_gather;
    logic        r_finished, n_finished;

    // output register
    logic              r_out_valid;
    wse_pkg::t_result  r_out;
    wse_pkg::t_result  n_res;

    logic in_acc;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.st, r_out.bits};
    assign m_axis_tuser  = {r_out.stv, r_out.sv};
    assign m_axis_tlast  = r_out.last;

    // exact int16 / 32768 as float32
    function automatic logic [31:0] pcm_to_float(input logic [15:0] raw);
        logic        neg;
        logic [15:0] mag;
        logic [3:0]  p;
        logic [23:0] sh;
        logic [7:0]  ex;
        neg = raw[15];
        mag = neg ? (16'd0 - raw) : raw;
        p   = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (mag[i]) p = 4'(i);
        end
        sh = {8'd0, mag} << (5'd23 - {1'b0, p});
        ex = 8'd112 + {4'd0, p};
        if (mag == 16'd0) return 32'd0;
        return {neg, ex, sh[22:0]};
    endfunction

    always_comb begin
        logic [2:0]  k;
        logic [3:0]  kr;
        logic        flt;
        logic        pcm_ok;
        logic        flt_ok;
        logic [1:0]  pos;
        logic [31:0] w;
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_tag      = r_tag;
        n_len      = r_len;
        n_fmt      = r_fmt;
        n_chan     = r_chan;
        n_rate     = r_rate;
        n_width    = r_width;
        n_fmt_seen = r_fmt_seen;
        n_pad      = r_pad;
        n_gather   = r_gather;
        n_finished = r_finished;
        n_res      = '0;
        k      = r_cnt[2:0];
        kr     = r_cnt[3:0];
        flt    = (r_fmt == wse_pkg::FMT_FLOAT);
        pcm_ok = (r_fmt == wse_pkg::FMT_PCM) && (r_width == 16'd16);
        flt_ok = flt && (r_width == 16'd32);
        pos    = r_cnt[1:0] & (flt ? 2'd3 : 2'd1);
        w      = {s_axis_tdata, r_gather};

        if (!r_finished) begin
            unique case (r_phase)
                wse_pkg::PH_RIFF: begin
                    if (kr < 4'd4)
                        n_tag[8*kr[1:0] +: 8] = s_axis_tdata;
                    else if (kr >= 4'd8)
                        n_len[8*kr[1:0] +: 8] = s_axis_tdata;
                    n_cnt = {28'd0, kr} + 32'd1;
                    if (kr == 4'd11) begin
                        n_cnt = '0;
                        if (n_tag != wse_pkg::TAG_RIFF || n_len != wse_pkg::TAG_WAVE) begin
                            n_res.stv = 1'b1;
                            n_res.st  = wse_pkg::ST_BAD_TAGS;
                        end else begin
                            n_phase = wse_pkg::PH_HDR;
                        end
                    end
                end
                wse_pkg::PH_HDR: begin
                    if (r_pad) begin
                        n_pad = 1'b0;
                    end else begin
                        if (!k[2]) n_tag[8*k[1:0] +: 8] = s_axis_tdata;
                        else       n_len[8*k[1:0] +: 8] = s_axis_tdata;
                        n_cnt = {29'd0, k} + 32'd1;
                        if (k == 3'd7) begin
                            n_cnt = '0;
                            if (n_len > r_max_chk) begin
                                n_res.stv = 1'b1;
                                n_res.st  = wse_pkg::ST_TOO_LARGE;
                            end else if (n_tag == wse_pkg::TAG_FMT) begin
                                if (n_len < 32'd16) begin
                                    n_res.stv = 1'b1;
                                    n_res.st  = wse_pkg::ST_FMT_SMALL;
                                end else begin
                                    n_phase = wse_pkg::PH_FMT;
                                end
                            end else if (n_tag == wse_pkg::TAG_DATA) begin
                                if (n_len == 32'd0) begin
                                    n_phase = wse_pkg::PH_HDR;
                                end else if (!r_fmt_seen) begin
                                    n_res.stv = 1'b1;
                                    n_res.st  = wse_pkg::ST_DATA_1ST;
                                end else if (r_chan != r_req_chan || r_rate != r_req_rate) begin
                                    n_res.stv = 1'b1;
                                    n_res.st  = wse_pkg::ST_CHAN_RATE;
                                end else if (!pcm_ok && !flt_ok) begin
                                    n_res.stv = 1'b1;
                                    n_res.st  = wse_pkg::ST_FORMAT;
                                end else if ((n_len[1:0] & (flt_ok ? 2'd3 : 2'd1)) != 2'd0) begin
                                    n_res.stv = 1'b1;
                                    n_res.st  = wse_pkg::ST_PARTIAL;
                                end else begin
                                    n_gather = '0;
                                    n_phase  = wse_pkg::PH_DATA;
                                end
                            end else if (n_len != 32'd0) begin
                                n_phase = wse_pkg::PH_SKIP;
                            end
                        end
                    end
                end
                wse_pkg::PH_FMT: begin
                    if (r_cnt[31:4] == 28'd0) begin
                        case (kr)
                            4'd0:  n_fmt   = {8'd0, s_axis_tdata};
                            4'd1:  n_fmt[15:8] = s_axis_tdata;
                            4'd2:  n_chan  = {8'd0, s_axis_tdata};
                            4'd3:  n_chan[15:8] = s_axis_tdata;
                            4'd4:  n_rate  = {24'd0, s_axis_tdata};
                            4'd5:  n_rate[15:8]  = s_axis_tdata;
                            4'd6:  n_rate[23:16] = s_axis_tdata;
                            4'd7:  n_rate[31:24] = s_axis_tdata;
                            4'd14: n_width = {8'd0, s_axis_tdata};
                            4'd15: n_width[15:8] = s_axis_tdata;
                            default: ;
                        endcase
                    end
                    n_cnt = r_cnt + 32'd1;
                    if (n_cnt == r_len) begin
                        n_fmt_seen = 1'b1;
                        n_cnt      = '0;
                        n_pad      = r_len[0];
                        n_phase    = wse_pkg::PH_HDR;
                    end
                end
                wse_pkg::PH_SKIP: begin
                    n_cnt = r_cnt + 32'd1;
                    if (n_cnt == r_len) begin
                        n_cnt   = '0;
                        n_pad   = r_len[0];
                        n_phase = wse_pkg::PH_HDR;
                    end
                end
                wse_pkg::PH_DATA: begin
                    n_cnt = r_cnt + 32'd1;
                    if (pos != (flt ? 2'd3 : 2'd1)) begin
                        if (pos == 2'd0) n_gather = {16'd0, s_axis_tdata};
                        else             n_gather[8*pos +: 8] = s_axis_tdata;
                    end else if (flt && ((w & wse_pkg::FLT_EXP_ALL) == wse_pkg::FLT_EXP_ALL)) begin
                        n_res.stv = 1'b1;
                        n_res.st  = wse_pkg::ST_NONFINITE;
                    end else begin
                        n_res.sv = 1'b1;
                        if (flt)
                            n_res.bits = ({1'b0, w[30:0]} > wse_pkg::FLT_ONE_MAG) ?
                                         ({w[31], 31'd0} | wse_pkg::FLT_ONE_MAG) : w;
                        else
                            n_res.bits = pcm_to_float({s_axis_tdata, r_gather[7:0]});
                        if (n_cnt == r_len) begin
                            n_res.last = 1'b1;
                            n_res.stv  = 1'b1;
                            n_res.st   = wse_pkg::ST_OK;
                        end
                    end
                end
                default: ;
            endcase

            if (n_res.stv) begin
                n_finished = 1'b1;
                n_phase    = wse_pkg::PH_DONE;
            end else if (s_axis_tlast) begin
                n_res.stv  = 1'b1;
                n_res.st   = (n_phase == wse_pkg::PH_HDR && (n_pad || n_cnt == 32'd0)) ?
                             wse_pkg::ST_MISSING : wse_pkg::ST_TRUNC;
                n_finished = 1'b1;
                n_phase    = wse_pkg::PH_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_chan  <= wse_pkg::CFG_CHANNELS_RST;
            r_req_rate  <= wse_pkg::CFG_RATE_RST;
            r_max_chk   <= wse_pkg::CFG_MAXCHK_RST;
            r_phase     <= wse_pkg::PH_RIFF;
            r_cnt       <= '0;
            r_tag       <= '0;
            r_len       <= '0;
            r_fmt       <= '0;
            r_chan      <= '0;
            r_rate      <= '0;
            r_width     <= '0;
            r_fmt_seen  <= 1'b0;
            r_pad       <= 1'b0;
            r_gather    <= '0;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    wse_pkg::CFG_CHANNELS: r_req_chan <= i_cfg_data[15:0];
                    wse_pkg::CFG_RATE:     r_req_rate <= i_cfg_data;
                    wse_pkg::CFG_MAXCHK:   r_max_chk  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_phase    <= n_phase;
                r_cnt      <= n_cnt;
                r_tag      <= n_tag;
                r_len      <= n_len;
                r_fmt      <= n_fmt;
                r_chan     <= n_chan;
                r_rate     <= n_rate;
                r_width    <= n_width;
                r_fmt_seen <= n_fmt_seen;
                r_pad      <= n_pad;
                r_gather   <= n_gather;
                r_finished <= n_finished;
            end
            if (in_acc && (n_res.sv || n_res.stv)) begin
                r_out_valid <= 1'b1;
                r_out       <= n_res;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished == (r_phase == wse_pkg::PH_DONE))
        else $error("finished flag and phase disagree");
    a_status_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.stv |-> r_finished)
        else $error("status sent while parse still running");
    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.last |-> r_out.sv && r_out.stv && r_out.st == wse_pkg::ST_OK)
        else $error("last sample without ok status");
    a_no_out_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_finished |=> !r_out_valid || $stable(r_out))
        else $error("result after parse end");
`endif

endmodule

`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for the WAV stream sample extractor. It programs the format
// registers, streams one RIFF/WAVE file a byte at a time (odd and empty
// chunks, pad bytes, a fmt rewrite, then a long data chunk of PCM16 or
// float32 samples), and checks every output item against a parser
// predictor kept in the bench. The block stays done after its status, so
// the run parses exactly one file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic        sv;
        logic [31:0] bits;
        logic        last;
        logic        stv;
        logic [3:0]  st;
    } t_sample_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    wav_stream_sample_extractor_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] file_byte
        .s_axis_tlast  (s_axis_tlast),   // end_of_file
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] sample_bits, [35:32] status
        .m_axis_tuser  (m_axis_tuser),   // [0] sample_valid, [1] status_valid
        .m_axis_tlast  (m_axis_tlast),   // last_sample
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser predictor: own copy of the registers and parse state.
    // ------------------------------------------------------------------
    logic [15:0] want_channels;
    logic [31:0] want_rate;
    logic [31:0] chunk_cap;

    wse_pkg::t_phase ph;
    logic [31:0] cnt;
    logic [31:0] tag;
    logic [31:0] clen;
    logic [15:0] fcode;
    logic [15:0] fchan;
    logic [31:0] frate;
    logic [15:0] fbits;
    bit          fmt_ok;
    bit          pad_due;
    logic [31:0] gather;
    bit          parse_over;
    t_sample_out outcome;

    t_sample_out sample_fifo[$];
    int          errors = 0;
    int unsigned cycles = 0;

    task automatic report(input string what);
        errors++;
        $display("mismatch @%0t: %s", $realtime, what);
    endtask

    task automatic queue_expect(input t_sample_out o);
        sample_fifo = {sample_fifo, o};
    endtask

    function automatic logic [31:0] pcm_to_f32(input logic [15:0] raw);
        logic [16:0] mag;
        logic [31:0] m32;
        int          p;
        if (raw == 16'd0) return 32'd0;
        mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        p = 0;
        for (int i = 0; i < 17; i++) if (mag[i]) p = i;
        m32 = {15'd0, mag} << (23 - p);
        return {raw[15], 8'(p + 112), m32[22:0]};
    endfunction

    task automatic stop_parse(input wse_pkg::t_status code);
        outcome.stv = 1'b1;
        outcome.st  = code;
        parse_over  = 1'b1;
        ph          = wse_pkg::PH_DONE;
    endtask

    task automatic close_chunk();
        cnt     = 0;
        pad_due = clen[0];
        ph      = wse_pkg::PH_HDR;
    endtask

    task automatic chunk_header_done();
        bit pcm, flt;
        cnt = 0;
        pcm = (fcode == wse_pkg::FMT_PCM && fbits == 16'd16);
        flt = (fcode == wse_pkg::FMT_FLOAT && fbits == 16'd32);
        if (clen > chunk_cap) stop_parse(wse_pkg::ST_TOO_LARGE);
        else if (tag == wse_pkg::TAG_FMT) begin
            if (clen < 16) stop_parse(wse_pkg::ST_FMT_SMALL);
            else ph = wse_pkg::PH_FMT;
        end else if (tag == wse_pkg::TAG_DATA) begin
            if (clen == 0) return;
            if (!fmt_ok) stop_parse(wse_pkg::ST_DATA_1ST);
            else if (fchan != want_channels || frate != want_rate)
                stop_parse(wse_pkg::ST_CHAN_RATE);
            else if (!pcm && !flt) stop_parse(wse_pkg::ST_FORMAT);
            else if ((clen & (flt ? 32'd3 : 32'd1)) != 0) stop_parse(wse_pkg::ST_PARTIAL);
            else begin
                gather = 0;
                ph = wse_pkg::PH_DATA;
            end
        end else if (clen != 0) ph = wse_pkg::PH_SKIP;
    endtask

    task automatic sample_byte(input logic [7:0] b);
        bit          flt;
        logic [31:0] sz, pos, w;
        flt = (fcode == wse_pkg::FMT_FLOAT);
        sz  = flt ? 4 : 2;
        pos = cnt & (sz - 1);
        cnt++;
        if (pos + 1 < sz) begin
            if (pos == 0) gather = {24'd0, b};
            else gather = (gather | ({24'd0, b} << (8 * pos))) & 32'hFF_FFFF;
            return;
        end
        if (flt) begin
            w = gather | {b, 24'd0};
            if ((w & wse_pkg::FLT_EXP_ALL) == wse_pkg::FLT_EXP_ALL) begin
                stop_parse(wse_pkg::ST_NONFINITE);
                return;
            end
            if ((w & 32'h7FFF_FFFF) > wse_pkg::FLT_ONE_MAG)
                w = (w & 32'h8000_0000) | wse_pkg::FLT_ONE_MAG;
            outcome.bits = w;
        end else begin
            outcome.bits = pcm_to_f32({b, gather[7:0]});
        end
        outcome.sv = 1'b1;
        if (cnt == clen) begin
            outcome.last = 1'b1;
            outcome.stv  = 1'b1;
            outcome.st   = wse_pkg::ST_OK;
            parse_over   = 1'b1;
            ph           = wse_pkg::PH_DONE;
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input bit eof);
        logic [31:0] k;
        if (parse_over) return;
        outcome = '0;
        case (ph)
            wse_pkg::PH_RIFF: begin
                k = cnt & 15;
                if (k < 4) tag = (k == 0) ? {24'd0, b} : (tag | ({24'd0, b} << (8 * k)));
                else if (k >= 8 && k < 12)
                    clen = (k == 8) ? {24'd0, b} : (clen | ({24'd0, b} << (8 * (k - 8))));
                cnt = k + 1;
                if (cnt >= 12) begin
                    cnt = 0;
                    if (tag != wse_pkg::TAG_RIFF || clen != wse_pkg::TAG_WAVE)
                        stop_parse(wse_pkg::ST_BAD_TAGS);
                    else ph = wse_pkg::PH_HDR;
                end
            end
            wse_pkg::PH_HDR: begin
                if (pad_due) pad_due = 1'b0;
                else begin
                    k = cnt & 7;
                    if (k < 4) tag = (k == 0) ? {24'd0, b} : (tag | ({24'd0, b} << (8 * k)));
                    else clen = (k == 4) ? {24'd0, b} : (clen | ({24'd0, b} << (8 * (k - 4))));
                    cnt = k + 1;
                    if (cnt == 8) chunk_header_done();
                end
            end
            wse_pkg::PH_FMT: begin
                case (cnt)
                    0:  fcode[7:0]   = b;
                    1:  fcode[15:8]  = b;
                    2:  fchan[7:0]   = b;
                    3:  fchan[15:8]  = b;
                    4:  frate[7:0]   = b;
                    5:  frate[15:8]  = b;
                    6:  frate[23:16] = b;
                    7:  frate[31:24] = b;
                    14: fbits[7:0]   = b;
                    15: fbits[15:8]  = b;
                    default: ;
                endcase
                // low byte write clears the high part
                if (cnt == 0) fcode[15:8] = 8'd0;
                if (cnt == 2) fchan[15:8] = 8'd0;
                if (cnt == 4) frate[31:8] = 24'd0;
                if (cnt == 14) fbits[15:8] = 8'd0;
                cnt++;
                if (cnt == clen) begin
                    fmt_ok = 1'b1;
                    close_chunk();
                end
            end
            wse_pkg::PH_SKIP: begin
                cnt++;
                if (cnt == clen) close_chunk();
            end
            wse_pkg::PH_DATA: sample_byte(b);
            default: ;
        endcase
        if (eof && !parse_over) begin
            if (ph == wse_pkg::PH_HDR && (pad_due || cnt == 0)) stop_parse(wse_pkg::ST_MISSING);
            else stop_parse(wse_pkg::ST_TRUNC);
        end
        if (outcome.sv || outcome.stv) queue_expect(outcome);
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    int burst_left = 0;

    // Sender works in bursts; valid stays high across items inside a burst.
    task automatic send_byte(input logic [7:0] b, input bit eof);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eof;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_byte(b, eof);
        burst_left--;
    endtask

    task automatic send_word(input logic [31:0] w, input int nbytes);
        for (int i = 0; i < nbytes; i++) send_byte(w[8 * i +: 8], 1'b0);
    endtask

    task automatic send_chunk_hdr(input logic [31:0] t, input logic [31:0] len);
        send_word(t, 4);
        send_word(len, 4);
    endtask

    // Caller lowers valid after the last write so it never toggles in one step.
    task automatic write_reg(input wse_pkg::t_cfg_index idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            wse_pkg::CFG_CHANNELS: want_channels = val[15:0];
            wse_pkg::CFG_RATE:     want_rate = val;
            wse_pkg::CFG_MAXCHK:   chunk_cap = val;
            default: ;
        endcase
    endtask

    // Receiver: alternating clean and choppy windows of ready.
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 300;
        if (stall_phase < 100) m_axis_tready <= 1'b1;
        else if (stall_phase < 200) m_axis_tready <= ($urandom_range(0, 3) != 0);
        else m_axis_tready <= ($urandom_range(0, 2) == 0);
    end

    // Result checker: every output item against the oldest expectation.
    always @(posedge i_clk) begin
        t_sample_out exp_o;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (sample_fifo.size() == 0) report("unexpected output item");
            else begin
                exp_o = sample_fifo.pop_front();
                if (m_axis_tuser[0] !== exp_o.sv)
                    report($sformatf("sample_valid %b exp %b", m_axis_tuser[0], exp_o.sv));
                if (m_axis_tdata[31:0] !== exp_o.bits)
                    report($sformatf("sample_bits %h exp %h", m_axis_tdata[31:0], exp_o.bits));
                if (m_axis_tlast !== exp_o.last)
                    report($sformatf("last_sample %b exp %b", m_axis_tlast, exp_o.last));
                if (m_axis_tuser[1] !== exp_o.stv)
                    report($sformatf("status_valid %b exp %b", m_axis_tuser[1], exp_o.stv));
                if (m_axis_tdata[35:32] !== exp_o.st)
                    report($sformatf("status %0d exp %0d", m_axis_tdata[35:32], exp_o.st));
                if (m_axis_tdata[39:36] !== 4'd0) report("tdata pad bits not zero");
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    bit          use_float;
    int          n_samples;
    logic [15:0] chans;
    logic [31:0] rate;
    int          sent_samples;

    // Registers: extremes first, final values last.
    task automatic test_registers();
        write_reg(wse_pkg::CFG_CHANNELS, 32'd65535);
        write_reg(wse_pkg::CFG_RATE, 32'd1);
        write_reg(wse_pkg::CFG_MAXCHK, 32'd16);
        write_reg(wse_pkg::CFG_RATE, 32'hFFFF_FFFF);
        write_reg(wse_pkg::CFG_MAXCHK, 32'hFFFF_FFFF);
        write_reg(wse_pkg::CFG_CHANNELS, 32'd1);
        chans = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 65535)) :
                ($urandom_range(0, 1) ? 16'd65535 : 16'd1);
        rate  = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 192000));
        write_reg(wse_pkg::CFG_CHANNELS, {16'd0, chans});
        write_reg(wse_pkg::CFG_RATE, rate);
        // the data chunk is the largest; sometimes exactly at the cap
        write_reg(wse_pkg::CFG_MAXCHK, n_samples * (use_float ? 4 : 2) + $urandom_range(0, 2));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_fmt(input logic [15:0] code, input logic [15:0] ch,
                            input logic [31:0] r, input logic [15:0] bw, input int len);
        send_chunk_hdr(wse_pkg::TAG_FMT, len);
        send_word({ch, code}, 4);
        send_word(r, 4);
        send_word($urandom, 4);
        send_word({bw, 16'($urandom)}, 4);
        for (int i = 16; i < len; i++) send_byte(8'($urandom), 1'b0);
        if (len % 2) send_byte(8'($urandom), 1'b0);
    endtask

    // Header, odd chunk with pad, empty data, overwritten fmt, empty chunk.
    task automatic test_chunk_walk();
        send_word(wse_pkg::TAG_RIFF, 4);
        send_word($urandom, 4);
        send_word(wse_pkg::TAG_WAVE, 4);
        send_chunk_hdr(32'h4B4E_554A, 32'd5);
        for (int i = 0; i < 6; i++) send_byte(8'($urandom), 1'b0);
        send_chunk_hdr(wse_pkg::TAG_DATA, 32'd0);
        send_fmt(16'd2, ~chans, ~rate, 16'd8, 16);
        send_chunk_hdr(32'h5453_494C, 32'd0);
        send_fmt(use_float ? wse_pkg::FMT_FLOAT : wse_pkg::FMT_PCM, chans, rate,
                 use_float ? 16'd32 : 16'd16, 17);
        send_chunk_hdr(wse_pkg::TAG_DATA, n_samples * (use_float ? 4 : 2));
    endtask

    task automatic send_sample(input logic [31:0] v, input bit eof);
        int nb;
        nb = use_float ? 4 : 2;
        for (int i = 0; i < nb; i++) send_byte(v[8 * i +: 8], eof && i == nb - 1);
        sent_samples++;
    endtask

    // Zeros, signs, subnormals, unity, clamp and full-scale codes.
    task automatic test_edge_samples();
        logic [31:0] fl[10];
        logic [15:0] pc[8];
        fl = '{32'h0, 32'h8000_0000, 32'h1, 32'h8000_0001, 32'h3F80_0000,
               32'hBF80_0000, 32'h3F80_0001, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'h007F_FFFF};
        pc = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h8001, 16'h4000, 16'hC000};
        if (use_float) foreach (fl[i]) send_sample(fl[i], 1'b0);
        else foreach (pc[i]) send_sample({16'd0, pc[i]}, 1'b0);
    endtask

    task automatic test_random_samples(input bit end_nonfinite);
        logic [31:0] v;
        while (sent_samples < n_samples) begin
            v = $urandom;
            if (use_float) begin
                if ($urandom_range(0, 1)) v[30:23] = 8'($urandom_range(100, 127));
                if ((v & wse_pkg::FLT_EXP_ALL) == wse_pkg::FLT_EXP_ALL) v[30] = 1'b0;
                if (sent_samples == n_samples - 1 && end_nonfinite)
                    v = v | wse_pkg::FLT_EXP_ALL;
            end
            // end_of_file on the final byte is ignored, as that byte already ends the parse
            send_sample(v, sent_samples == n_samples - 1 && $urandom_range(0, 1));
        end
    endtask

    // Bytes after the parse end, end_of_file among them, give nothing.
    task automatic test_after_end();
        for (int i = 0; i < 12; i++) send_byte(8'($urandom), i % 4 == 3);
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        bit bad_tail;
        want_channels = wse_pkg::CFG_CHANNELS_RST;
        want_rate     = wse_pkg::CFG_RATE_RST;
        chunk_cap     = wse_pkg::CFG_MAXCHK_RST;
        ph = wse_pkg::PH_RIFF; cnt = 0; tag = 0; clen = 0;
        fcode = 0; fchan = 0; frate = 0; fbits = 0;
        fmt_ok = 0; pad_due = 0; gather = 0; parse_over = 0;
        sent_samples = 0;
        use_float = $urandom_range(0, 1);
        n_samples = use_float ? 300 : 600;
        bad_tail  = use_float && $urandom_range(0, 1);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_registers();
        test_chunk_walk();
        test_edge_samples();
        test_random_samples(bad_tail);
        test_after_end();

        while (sample_fifo.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
